// File: hdl/ntc_code_to_temperature_core_assert.svh
// Assertion macros for the thermistor converter core.
// Included by the top level; no other dependencies.
`ifndef NTC_CODE_TO_TEMPERATURE_CORE_ASSERT_SVH
`define NTC_CODE_TO_TEMPERATURE_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define NTC_ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed: label");

// next-cycle implication, disabled in reset
`define NTC_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed: label");

`endif

// File: hdl/ntc_pkg.sv
// Shared types, constants and temperature tables for the thermistor converter.
// No dependencies.
`default_nettype none

package ntc_pkg;

    localparam logic [15:0] REF_OHMS_RESET   = 16'd33000;
    localparam logic [24:0] FULL_SCALE_RESET = 25'd8388608;

    localparam logic REG_REFERENCE_OHMS  = 1'b0;
    localparam logic REG_FULL_SCALE_CODE = 1'b1;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_COLD   = 2'd2;
    localparam logic [1:0] ST_HOT    = 2'd3;

    localparam logic [23:0] CODE_MID_BAD  = 24'h7FFFFF;
    localparam logic [23:0] CODE_FULL_BAD = 24'hFFFFFF;

    localparam logic [15:0] COLD_LIMIT   = 16'd8301;
    localparam logic [15:0] COLD_NEG_MIN = 16'd28241;
    localparam logic [15:0] MID_BASE     = 16'd4170;
    localparam logic [15:0] HOT_CLAMP    = 16'd10000;
    localparam logic [15:0] COLD_LAST_T  = 16'd2995;

    typedef enum logic [1:0] {
        SEG_COLD,
        SEG_MID,
        SEG_HOT
    } seg_t;

    typedef struct packed {
        logic        valid;
        logic        rej;
        logic [15:0] ohms;
    } div_res_t;

    localparam logic [15:0] TAB_HOT [0:24] = '{
        16'd5000, 16'd5101, 16'd5206, 16'd5314, 16'd5428, 16'd5546, 16'd5670, 16'd5800,
        16'd5937, 16'd6080, 16'd6232, 16'd6393, 16'd6563, 16'd6744, 16'd6938, 16'd7144,
        16'd7368, 16'd7610, 16'd7871, 16'd8159, 16'd8477, 16'd8828, 16'd9226, 16'd9679,
        16'd10200
    };

    localparam logic [15:0] TAB_COLD [0:24] = '{
        16'd62, 16'd127, 16'd195, 16'd266, 16'd339, 16'd414, 16'd493, 16'd576,
        16'd661, 16'd751, 16'd845, 16'd943, 16'd1047, 16'd1156, 16'd1271, 16'd1393,
        16'd1522, 16'd1660, 16'd1808, 16'd1966, 16'd2137, 16'd2323, 16'd2526, 16'd2748,
        16'd2995
    };

    localparam logic [15:0] TAB_MID [0:153] = '{
        16'd4993, 16'd4973, 16'd4953, 16'd4933, 16'd4914, 16'd4895, 16'd4875, 16'd4856,
        16'd4837, 16'd4819, 16'd4800, 16'd4782, 16'd4763, 16'd4745, 16'd4727, 16'd4709,
        16'd4691, 16'd4673, 16'd4656, 16'd4638, 16'd4621, 16'd4604, 16'd4587, 16'd4570,
        16'd4553, 16'd4536, 16'd4519, 16'd4503, 16'd4486, 16'd4470, 16'd4454, 16'd4438,
        16'd4421, 16'd4406, 16'd4390, 16'd4374, 16'd4358, 16'd4343, 16'd4327, 16'd4312,
        16'd4297, 16'd4282, 16'd4267, 16'd4252, 16'd4237, 16'd4222, 16'd4207, 16'd4193,
        16'd4178, 16'd4164, 16'd4149, 16'd4135, 16'd4121, 16'd4107, 16'd4093, 16'd4079,
        16'd4065, 16'd4051, 16'd4037, 16'd4024, 16'd4010, 16'd3996, 16'd3983, 16'd3970,
        16'd3956, 16'd3943, 16'd3930, 16'd3917, 16'd3904, 16'd3891, 16'd3878, 16'd3865,
        16'd3853, 16'd3840, 16'd3827, 16'd3815, 16'd3802, 16'd3790, 16'd3778, 16'd3765,
        16'd3753, 16'd3741, 16'd3729, 16'd3717, 16'd3705, 16'd3693, 16'd3681, 16'd3669,
        16'd3658, 16'd3646, 16'd3634, 16'd3623, 16'd3611, 16'd3600, 16'd3588, 16'd3577,
        16'd3566, 16'd3555, 16'd3543, 16'd3532, 16'd3521, 16'd3510, 16'd3499, 16'd3488,
        16'd3477, 16'd3467, 16'd3456, 16'd3445, 16'd3434, 16'd3424, 16'd3413, 16'd3403,
        16'd3392, 16'd3382, 16'd3371, 16'd3361, 16'd3351, 16'd3340, 16'd3330, 16'd3320,
        16'd3310, 16'd3300, 16'd3290, 16'd3280, 16'd3270, 16'd3260, 16'd3250, 16'd3240,
        16'd3230, 16'd3220, 16'd3211, 16'd3201, 16'd3191, 16'd3182, 16'd3172, 16'd3163,
        16'd3153, 16'd3144, 16'd3134, 16'd3125, 16'd3116, 16'd3107, 16'd3097, 16'd3088,
        16'd3079, 16'd3070, 16'd3061, 16'd3052, 16'd3043, 16'd3034, 16'd3025, 16'd3016,
        16'd3007, 16'd2998
    };

    function automatic logic [15:0] tab_lookup(input seg_t seg, input logic [7:0] idx);
        logic [15:0] t;
        t = '0;
        case (seg)
            SEG_COLD: t = TAB_COLD[idx[4:0]];
            SEG_MID:  t = TAB_MID[idx];
            SEG_HOT:  t = TAB_HOT[idx[4:0]];
            default:  t = '0;
        endcase
        return t;
    endfunction

    // ohm step of each segment
    function automatic logic [9:0] seg_step(input seg_t seg);
        logic [9:0] s;
        s = 10'd796;
        case (seg)
            SEG_COLD: s = 10'd796;
            SEG_MID:  s = 10'd27;
            SEG_HOT:  s = 10'd132;
            default:  s = 10'd796;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// File: hdl/ntc_div.sv
// Pipelined restoring divider: ohms = min(num / den, 65535), one bit per stage.
// Depends on ntc_pkg.
`default_nettype none

module ntc_div (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic             in_valid,
    input  wire logic             in_rej,
    input  wire logic [39:0]      num,
    input  wire logic [24:0]      den,
    output ntc_pkg::div_res_t     res
);

    logic [16:0] v_reg;
    logic        rej_reg [0:16];
    logic        sat_reg [0:16];
    logic [39:0] rem_reg [0:16];
    logic [15:0] q_reg   [0:16];

    // saturation check; a zero divisor always saturates here
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num;
            sat_reg[0] <= ({1'b0, num} >= {den, 16'b0});
            q_reg[0]   <= '0;
            rej_reg[0] <= in_rej;
        end
    end

    for (genvar i = 1; i <= 16; i++)
    begin : g_bit
        localparam int B = 16 - i;
        logic [40:0] dsh;
        logic        ge;
        logic [39:0] rem_next;
        logic [15:0] q_next;

        always_comb
        begin
            dsh      = {16'b0, den} << B;
            ge       = ({1'b0, rem_reg[i-1]} >= dsh);
            rem_next = ge ? (rem_reg[i-1] - dsh[39:0]) : rem_reg[i-1];
            q_next   = q_reg[i-1];
            q_next[B] = ge;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= rem_next;
                q_reg[i]   <= q_next;
                sat_reg[i] <= sat_reg[i-1];
                rej_reg[i] <= rej_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[15:0], in_valid};
        end
    end

    assign res.valid = v_reg[16];
    assign res.rej   = rej_reg[16];
    assign res.ohms  = sat_reg[16] ? 16'hFFFF : q_reg[16];

endmodule

`default_nettype wire

// File: hdl/ntc_interp.sv
// Segment select, table index, interpolation and status, ten pipeline stages.
// Depends on ntc_pkg.
`default_nettype none

module ntc_interp (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire ntc_pkg::div_res_t din,
    output logic                   out_valid,
    output logic [15:0]            temperature_x100,
    output logic [1:0]             status
);

    typedef struct packed {
        ntc_pkg::seg_t seg;
        logic          rej;
        logic          neg;
        logic          past;
    } ctx_t;

    logic [9:0] v_reg;

    // stage A: segment and distance into it
    ctx_t               ctx_a_next;
    logic [15:0]        d_a_next;
    logic signed [16:0] ds_a_next;

    always_comb
    begin
        ctx_a_next      = '0;
        ctx_a_next.rej  = din.rej;
        ds_a_next       = '0;
        d_a_next        = '0;
        if (din.ohms > ntc_pkg::COLD_LIMIT)
        begin
            ctx_a_next.seg = ntc_pkg::SEG_COLD;
            ctx_a_next.neg = (din.ohms >= ntc_pkg::COLD_NEG_MIN);
            ds_a_next      = 17'sd27445 - $signed({1'b0, din.ohms});
            d_a_next       = ds_a_next[16] ? 16'd0 : ds_a_next[15:0];
        end
        else if (din.ohms >= ntc_pkg::MID_BASE)
        begin
            ctx_a_next.seg = ntc_pkg::SEG_MID;
            d_a_next       = din.ohms - ntc_pkg::MID_BASE;
            ds_a_next      = $signed({1'b0, d_a_next});
        end
        else
        begin
            ctx_a_next.seg = ntc_pkg::SEG_HOT;
            d_a_next       = ntc_pkg::MID_BASE - din.ohms;
            ds_a_next      = $signed({1'b0, d_a_next});
        end
    end

    ctx_t               ctx_a_reg;
    logic [15:0]        d_a_reg;
    logic signed [16:0] ds_a_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx_a_reg <= ctx_a_next;
            d_a_reg   <= d_a_next;
            ds_a_reg  <= ds_a_next;
        end
    end

    // stage B: reciprocal estimate of d / step (low by at most one)
    logic [15:0] m20_b;
    logic [31:0] prod_b;

    always_comb
    begin
        m20_b = 16'd1317;
        case (ctx_a_reg.seg)
            ntc_pkg::SEG_COLD: m20_b = 16'd1317;
            ntc_pkg::SEG_MID:  m20_b = 16'd38836;
            ntc_pkg::SEG_HOT:  m20_b = 16'd7943;
            default:           m20_b = 16'd1317;
        endcase
        prod_b = 32'(d_a_reg) * 32'(m20_b);
    end

    ctx_t               ctx_b_reg;
    logic [15:0]        d_b_reg;
    logic signed [16:0] ds_b_reg;
    logic [11:0]        q0_b_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx_b_reg <= ctx_a_reg;
            d_b_reg   <= d_a_reg;
            ds_b_reg  <= ds_a_reg;
            q0_b_reg  <= prod_b[31:20];
        end
    end

    // stage C: remainder of the estimate
    logic [9:0]  step_c;
    logic [21:0] qs_c;
    logic [15:0] rem_c;

    always_comb
    begin
        step_c = ntc_pkg::seg_step(ctx_b_reg.seg);
        qs_c   = 22'(q0_b_reg) * 22'(step_c);
        rem_c  = d_b_reg - qs_c[15:0];
    end

    ctx_t               ctx_c_reg;
    logic [15:0]        d_c_reg;
    logic signed [16:0] ds_c_reg;
    logic [11:0]        q0_c_reg;
    logic [10:0]        rem0_c_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx_c_reg  <= ctx_b_reg;
            d_c_reg    <= d_b_reg;
            ds_c_reg   <= ds_b_reg;
            q0_c_reg   <= q0_b_reg;
            rem0_c_reg <= rem_c[10:0];
        end
    end

    // stage D: correct index, clamp, distance from the lower table point
    logic [9:0]         step_d;
    logic               ge_d;
    logic [11:0]        idx_d;
    logic [10:0]        rem_d;
    ctx_t               ctx_d_next;
    logic [7:0]         idx_d_next;
    logic signed [16:0] dr_d_next;

    always_comb
    begin
        step_d     = ntc_pkg::seg_step(ctx_c_reg.seg);
        ge_d       = (rem0_c_reg >= {1'b0, step_d});
        idx_d      = q0_c_reg + {11'b0, ge_d};
        rem_d      = ge_d ? (rem0_c_reg - {1'b0, step_d}) : rem0_c_reg;
        ctx_d_next = ctx_c_reg;
        idx_d_next = idx_d[7:0];
        dr_d_next  = $signed({6'b0, rem_d});
        case (ctx_c_reg.seg)
            ntc_pkg::SEG_COLD:
            begin
                ctx_d_next.past = (idx_d >= 12'd24);
                if (idx_d >= 12'd24)
                begin
                    idx_d_next = 8'd23;
                end
                if (ds_c_reg[16])
                begin
                    dr_d_next = ds_c_reg;
                end
            end
            ntc_pkg::SEG_MID:
            begin
                if (idx_d >= 12'd153)
                begin
                    idx_d_next = 8'd152;
                    dr_d_next  = 17'sd4104 - $signed({1'b0, d_c_reg});
                end
                else
                begin
                    dr_d_next = -$signed({6'b0, rem_d});
                end
            end
            ntc_pkg::SEG_HOT:
            begin
                if (idx_d >= 12'd24)
                begin
                    idx_d_next = 8'd23;
                    dr_d_next  = $signed({1'b0, d_c_reg}) - 17'sd3036;
                end
            end
            default:
            begin
                idx_d_next = '0;
            end
        endcase
    end

    ctx_t               ctx_d_reg;
    logic [7:0]         idx_d_reg;
    logic signed [16:0] dr_d_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx_d_reg <= ctx_d_next;
            idx_d_reg <= idx_d_next;
            dr_d_reg  <= dr_d_next;
        end
    end

    // stage E: table reads
    logic [15:0]        t0_e;
    logic [15:0]        t1_e;
    logic signed [16:0] dt_e;

    always_comb
    begin
        t0_e = ntc_pkg::tab_lookup(ctx_d_reg.seg, idx_d_reg);
        t1_e = ntc_pkg::tab_lookup(ctx_d_reg.seg, idx_d_reg + 8'd1);
        dt_e = $signed({1'b0, t1_e}) - $signed({1'b0, t0_e});
    end

    ctx_t               ctx_e_reg;
    logic [15:0]        t0_e_reg;
    logic signed [16:0] dt_e_reg;
    logic signed [16:0] dr_e_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx_e_reg <= ctx_d_reg;
            t0_e_reg  <= t0_e;
            dt_e_reg  <= dt_e;
            dr_e_reg  <= dr_d_reg;
        end
    end

    // stage F: dr * dt
    logic signed [33:0] p_f;

    assign p_f = 34'(dr_e_reg) * 34'(dt_e_reg);

    ctx_t               ctx_f_reg;
    logic [15:0]        t0_f_reg;
    logic signed [21:0] p_f_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx_f_reg <= ctx_e_reg;
            t0_f_reg  <= t0_e_reg;
            p_f_reg   <= p_f[21:0];
        end
    end

    // stage G: magnitude and quotient sign (mid step runs negative)
    logic [21:0] pn_g;

    assign pn_g = -p_f_reg;

    ctx_t        ctx_g_reg;
    logic [15:0] t0_g_reg;
    logic [20:0] mag_g_reg;
    logic        qneg_g_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx_g_reg  <= ctx_f_reg;
            t0_g_reg   <= t0_f_reg;
            mag_g_reg  <= p_f_reg[21] ? pn_g[20:0] : p_f_reg[20:0];
            qneg_g_reg <= p_f_reg[21] ^ (ctx_f_reg.seg == ntc_pkg::SEG_MID);
        end
    end

    // stage H: reciprocal estimate of |p| / step
    logic [19:0] m24_h;
    logic [40:0] prod_h;

    always_comb
    begin
        m24_h = 20'd21076;
        case (ctx_g_reg.seg)
            ntc_pkg::SEG_COLD: m24_h = 20'd21076;
            ntc_pkg::SEG_MID:  m24_h = 20'd621378;
            ntc_pkg::SEG_HOT:  m24_h = 20'd127100;
            default:           m24_h = 20'd21076;
        endcase
        prod_h = 41'(mag_g_reg) * 41'(m24_h);
    end

    ctx_t        ctx_h_reg;
    logic [15:0] t0_h_reg;
    logic [20:0] mag_h_reg;
    logic        qneg_h_reg;
    logic [16:0] q0_h_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx_h_reg  <= ctx_g_reg;
            t0_h_reg   <= t0_g_reg;
            mag_h_reg  <= mag_g_reg;
            qneg_h_reg <= qneg_g_reg;
            q0_h_reg   <= prod_h[40:24];
        end
    end

    // stage I: remainder of the estimate
    logic [9:0]  step_i;
    logic [26:0] qs_i;
    logic [20:0] rem_i;

    always_comb
    begin
        step_i = ntc_pkg::seg_step(ctx_h_reg.seg);
        qs_i   = 27'(q0_h_reg) * 27'(step_i);
        rem_i  = mag_h_reg - qs_i[20:0];
    end

    ctx_t        ctx_i_reg;
    logic [15:0] t0_i_reg;
    logic        qneg_i_reg;
    logic [16:0] q0_i_reg;
    logic [10:0] rem0_i_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx_i_reg  <= ctx_h_reg;
            t0_i_reg   <= t0_h_reg;
            qneg_i_reg <= qneg_h_reg;
            q0_i_reg   <= q0_h_reg;
            rem0_i_reg <= rem_i[10:0];
        end
    end

    // stage J: final quotient, wrapped sum, status
    logic [9:0]  step_j;
    logic [16:0] q_j;
    logic [15:0] qv_j;
    logic [15:0] sum_j;
    logic [15:0] temp_next;
    logic [1:0]  status_next;

    always_comb
    begin
        step_j = ntc_pkg::seg_step(ctx_i_reg.seg);
        q_j    = q0_i_reg + {16'b0, (rem0_i_reg >= {1'b0, step_j})};
        qv_j   = qneg_i_reg ? (16'd0 - q_j[15:0]) : q_j[15:0];
        sum_j  = t0_i_reg + qv_j;
        if (ctx_i_reg.rej)
        begin
            temp_next   = '0;
            status_next = ntc_pkg::ST_REJECT;
        end
        else if (ctx_i_reg.seg == ntc_pkg::SEG_COLD && ctx_i_reg.neg)
        begin
            temp_next   = '0;
            status_next = ntc_pkg::ST_COLD;
        end
        else if (ctx_i_reg.seg == ntc_pkg::SEG_COLD && ctx_i_reg.past)
        begin
            temp_next   = ntc_pkg::COLD_LAST_T;
            status_next = ntc_pkg::ST_OK;
        end
        else
        begin
            temp_next   = sum_j;
            status_next = (sum_j >= ntc_pkg::HOT_CLAMP) ? ntc_pkg::ST_HOT : ntc_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            temperature_x100 <= temp_next;
            status           <= status_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[8:0], din.valid};
        end
    end

    assign out_valid = v_reg[9];

endmodule

`default_nettype wire

// File: hdl/ntc_code_to_temperature_core.sv
// Pipeline: 1 multiply, 17 divider and 10 interpolation stages from input transfer
// to result valid. Throughput: one item per cycle; the whole pipeline
// advances together and holds while a finished result waits for out_ready.
// Reset: asynchronous, active low; clears stage valids and loads the register
// defaults (33000 ohms, full scale 8388608).
// Depends on ntc_pkg, ntc_div, ntc_interp and the assertion macro header.
`default_nettype none

`include "ntc_code_to_temperature_core_assert.svh"

module ntc_code_to_temperature_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wen,
    input  wire logic        cfg_index,
    input  wire logic [24:0] cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [23:0] adc_code,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      temperature_x100,
    output logic [1:0]       status
);

    logic [15:0] ref_ohms_reg;
    logic [24:0] full_scale_reg;
    logic        en;
    logic        v1_reg;
    logic        rej1_reg;
    logic [39:0] prod1_reg;
    ntc_pkg::div_res_t div_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_ohms_reg   <= ntc_pkg::REF_OHMS_RESET;
            full_scale_reg <= ntc_pkg::FULL_SCALE_RESET;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                ntc_pkg::REG_REFERENCE_OHMS:  ref_ohms_reg   <= cfg_wdata[15:0];
                ntc_pkg::REG_FULL_SCALE_CODE: full_scale_reg <= cfg_wdata;
                default:                      ref_ohms_reg   <= ref_ohms_reg;
            endcase
        end
    end

    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod1_reg <= 40'(adc_code) * 40'(ref_ohms_reg);
            rej1_reg  <= (adc_code == 24'd0) || (adc_code == ntc_pkg::CODE_MID_BAD)
                         || (adc_code == ntc_pkg::CODE_FULL_BAD);
        end
    end

    ntc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (v1_reg),
        .in_rej   (rej1_reg),
        .num      (prod1_reg),
        .den      (full_scale_reg),
        .res      (div_res)
    );

    ntc_interp u_interp (
        .clk              (clk),
        .rst_n            (rst_n),
        .en               (en),
        .din              (div_res),
        .out_valid        (out_valid),
        .temperature_x100 (temperature_x100),
        .status           (status)
    );

    `NTC_ASSERT_IMPLY(a_zero_on_fault, clk, rst_n,
        out_valid && (status == ntc_pkg::ST_REJECT || status == ntc_pkg::ST_COLD),
        temperature_x100 == 16'd0)
    `NTC_ASSERT_IMPLY(a_ok_below_hot, clk, rst_n,
        out_valid && status == ntc_pkg::ST_OK, temperature_x100 < ntc_pkg::HOT_CLAMP)
    `NTC_ASSERT_IMPLY(a_hot_at_limit, clk, rst_n,
        out_valid && status == ntc_pkg::ST_HOT, temperature_x100 >= ntc_pkg::HOT_CLAMP)
    `NTC_ASSERT_NEXT(a_stall_holds, clk, rst_n,
        !in_ready, out_valid && $stable(temperature_x100) && $stable(status))

endmodule

`default_nettype wire
